### src/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg
// shared types, codes and sizes of the rescale handshake tracker
// ----------------------------------------------------------------------------
package rht_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int MAX_PAR   = 64;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MAP_W     = MAX_PAR;
  localparam int SUB_W     = 6;
  localparam int PAR_W     = 7;
  localparam int CKPT_W    = 64;

  // event modes
  localparam logic [2:0] MODE_REGISTER = 3'd0;
  localparam logic [2:0] MODE_REQUEST  = 3'd1;
  localparam logic [2:0] MODE_CKPT     = 3'd2;
  localparam logic [2:0] MODE_DRAINED  = 3'd3;
  localparam logic [2:0] MODE_READY    = 3'd4;
  localparam logic [2:0] MODE_ABORT    = 3'd5;
  localparam logic [2:0] MODE_QUERY    = 3'd6;

  // rescale states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_CUT   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;
  localparam logic [2:0] ST_ABORT = 3'd5;

  // status codes
  localparam logic [3:0] SC_OK        = 4'd0;
  localparam logic [3:0] SC_UNREG     = 4'd1;
  localparam logic [3:0] SC_NO_BOUNDS = 4'd2;
  localparam logic [3:0] SC_BELOW     = 4'd3;
  localparam logic [3:0] SC_ABOVE     = 4'd4;
  localparam logic [3:0] SC_EQUAL     = 4'd5;
  localparam logic [3:0] SC_BUSY      = 4'd6;
  localparam logic [3:0] SC_WRONG     = 4'd7;
  localparam logic [3:0] SC_NO_ABORT  = 4'd8;

  // one slot record
  typedef struct packed {
    logic [2:0]        state;
    logic [PAR_W-1:0]  cur;
    logic [PAR_W-1:0]  tgt;
    logic [PAR_W-1:0]  pmin;
    logic [PAR_W-1:0]  pmax;
    logic [CKPT_W-1:0] ckpt;
    logic [MAP_W-1:0]  dmap;
    logic [MAP_W-1:0]  rmap;
    logic [PAR_W-1:0]  dcnt;
    logic [PAR_W-1:0]  rcnt;
  } slot_rec_t;

  localparam int REC_W = $bits(slot_rec_t);

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic rd_en;
    logic update;
  } dp_cmd_t;

endpackage

### src/rht_ram.sv
// ----------------------------------------------------------------------------
// rht_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic                             re,
  input  logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] addr,
  input  logic [WIDTH-1:0]                 wdata,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### src/rht_datapath.sv
// ----------------------------------------------------------------------------
// rht_datapath
// slot table, event evaluation and result register
// ----------------------------------------------------------------------------
module rht_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  rht_pkg::dp_cmd_t              cmd,
  input  logic [2:0]                    mode,
  input  logic [3:0]                    op_slot,
  input  logic [6:0]                    parallelism,
  input  logic [6:0]                    par_min,
  input  logic [6:0]                    par_max,
  input  logic [5:0]                    subtask_index,
  input  logic [63:0]                   ckpt_id,
  output logic                          ok,
  output logic [3:0]                    status_code,
  output logic [2:0]                    rescale_state,
  output logic [6:0]                    current_out,
  output logic [6:0]                    target_out,
  output logic [6:0]                    min_out,
  output logic [6:0]                    max_out,
  output logic [63:0]                   cutover_out,
  output logic [6:0]                    drained_count,
  output logic [6:0]                    ready_count
);
  import rht_pkg::*;

  // captured event
  logic [2:0]        ev_mode;
  logic [3:0]        ev_slot;
  logic [PAR_W-1:0]  ev_par, ev_min, ev_max;
  logic [SUB_W-1:0]  ev_sub;
  logic [CKPT_W-1:0] ev_ckpt;

  logic [NUM_SLOTS-1:0] slot_valid;
  logic [REC_W-1:0]     rd_raw;
  slot_rec_t            rec, rec_next;
  logic                 in_range, vld, wr;
  logic [3:0]           code;
  logic                 okv;
  logic [MAP_W-1:0]     bit_m;
  logic [SLOT_W-1:0]    addr;

  assign in_range = ({28'd0, ev_slot} < 32'(NUM_SLOTS));
  assign addr     = cmd.capture ? SLOT_W'(op_slot) : SLOT_W'(ev_slot);
  assign vld      = in_range && slot_valid[SLOT_W'(ev_slot)];
  assign rec      = slot_rec_t'(rd_raw);
  assign bit_m    = ({26'd0, ev_sub} < 32'(MAX_PAR)) ?
                    (MAP_W'(1) << ev_sub) : '0;

  // event capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_mode <= mode;
      ev_slot <= op_slot;
      ev_par  <= parallelism;
      ev_min  <= par_min;
      ev_max  <= par_max;
      ev_sub  <= subtask_index;
      ev_ckpt <= ckpt_id;
    end
  end

  rht_ram #(.WIDTH(REC_W), .DEPTH(NUM_SLOTS)) u_table (
    .clk   (clk),
    .we    (wr),
    .re    (cmd.rd_en),
    .addr  (addr),
    .wdata (rec_next),
    .rdata (rd_raw)
  );

  // event evaluation
  always_comb begin
    rec_next = rec;
    code     = SC_OK;
    okv      = 1'b0;
    if (!in_range) begin
      code = SC_UNREG;
    end else if (ev_mode == MODE_REGISTER) begin
      rec_next.state = ST_IDLE;
      rec_next.cur   = ev_par;
      rec_next.tgt   = ev_par;
      rec_next.pmin  = ev_min;
      rec_next.pmax  = ev_max;
      rec_next.ckpt  = '0;
      rec_next.dmap  = '0;
      rec_next.rmap  = '0;
      rec_next.dcnt  = '0;
      rec_next.rcnt  = '0;
      okv = 1'b1;
    end else if (!vld) begin
      code = SC_UNREG;
    end else begin
      case (ev_mode)
        MODE_REQUEST: begin
          if (rec.pmin == '0 && rec.pmax == '0) code = SC_NO_BOUNDS;
          else if (ev_par < rec.pmin) code = SC_BELOW;
          else if (ev_par > rec.pmax) code = SC_ABOVE;
          else if (ev_par == rec.cur) code = SC_EQUAL;
          else if (rec.state == ST_PREP || rec.state == ST_DRAIN ||
                   rec.state == ST_CUT) code = SC_BUSY;
          else begin
            rec_next.tgt   = ev_par;
            rec_next.state = ST_PREP;
            rec_next.ckpt  = '0;
            rec_next.dmap  = '0;
            rec_next.rmap  = '0;
            rec_next.dcnt  = '0;
            rec_next.rcnt  = '0;
            okv = 1'b1;
          end
        end
        MODE_CKPT: begin
          if (rec.state != ST_PREP) code = SC_WRONG;
          else begin
            rec_next.ckpt  = ev_ckpt;
            rec_next.state = ST_DRAIN;
            okv = 1'b1;
          end
        end
        MODE_DRAINED: begin
          if (rec.state != ST_DRAIN) code = SC_WRONG;
          else begin
            if ((rec.dmap & bit_m) == '0 && bit_m != '0) begin
              rec_next.dmap = rec.dmap | bit_m;
              rec_next.dcnt = rec.dcnt + 7'd1;
            end
            if (rec_next.dcnt >= rec.cur) rec_next.state = ST_CUT;
            okv = 1'b1;
          end
        end
        MODE_READY: begin
          if (rec.state != ST_CUT) code = SC_WRONG;
          else begin
            if ((rec.rmap & bit_m) == '0 && bit_m != '0) begin
              rec_next.rmap = rec.rmap | bit_m;
              rec_next.rcnt = rec.rcnt + 7'd1;
            end
            if (rec_next.rcnt >= rec.tgt) begin
              rec_next.cur   = rec.tgt;
              rec_next.state = ST_DONE;
            end
            okv = 1'b1;
          end
        end
        MODE_ABORT: begin
          if (rec.state == ST_IDLE || rec.state == ST_DONE) code = SC_NO_ABORT;
          else begin
            rec_next.state = ST_ABORT;
            rec_next.tgt   = rec.cur;
            rec_next.ckpt  = '0;
            rec_next.dmap  = '0;
            rec_next.rmap  = '0;
            rec_next.dcnt  = '0;
            rec_next.rcnt  = '0;
            okv = 1'b1;
          end
        end
        MODE_QUERY: okv = 1'b1;
        default:    code = SC_WRONG;
      endcase
    end
  end

  assign wr = cmd.update && okv && (ev_mode != MODE_QUERY);

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (wr && ev_mode == MODE_REGISTER) begin
      slot_valid[SLOT_W'(ev_slot)] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      ok          <= okv;
      status_code <= code;
      if (code == SC_UNREG) begin
        rescale_state <= '0;
        current_out   <= '0;
        target_out    <= '0;
        min_out       <= '0;
        max_out       <= '0;
        cutover_out   <= '0;
        drained_count <= '0;
        ready_count   <= '0;
      end else begin
        rescale_state <= rec_next.state;
        current_out   <= rec_next.cur;
        target_out    <= rec_next.tgt;
        min_out       <= rec_next.pmin;
        max_out       <= rec_next.pmax;
        cutover_out   <= rec_next.ckpt;
        drained_count <= rec_next.dcnt;
        ready_count   <= rec_next.rcnt;
      end
    end
  end

endmodule

### src/rht_ctrl.sv
// ----------------------------------------------------------------------------
// rht_ctrl
// handshake sequencer: capture, table read, update, hold result
// ----------------------------------------------------------------------------
module rht_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output rht_pkg::dp_cmd_t cmd
);
  import rht_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EVAL = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready    = (state == S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign cmd.capture = in_valid && in_ready;
  assign cmd.rd_en   = cmd.capture;
  assign cmd.update  = (state == S_EVAL);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_EVAL;
      S_EVAL:  state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/rescale_handshake_tracker_unit.sv
// ----------------------------------------------------------------------------
// rescale_handshake_tracker_unit
// operator slot table tracking rescale handshakes
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one event beat: mode, op_slot,
//   parallelism, bounds, subtask_index and ckpt_id.
//   output channel (out_valid/out_ready) carries one result beat per event:
//   ok, status_code and the slot contents after the event.
//   an event is captured and its slot record read from the table ram in the
//   accept cycle, evaluated and written back in the next, and the result is
//   offered the cycle after that. a new event is taken once the result beat
//   is delivered, so the unit never works on two events at once; the
//   single-port slot ram read-modify-write is the reason.
//   reset clears the state machine and all slot valid bits; slot contents
//   are only used after a register event has written them.
//   while the receiver stalls the result holds and in_ready stays low.
// ----------------------------------------------------------------------------
module rescale_handshake_tracker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic [3:0]  op_slot,
  input  logic [6:0]  parallelism,
  input  logic [6:0]  par_min,
  input  logic [6:0]  par_max,
  input  logic [5:0]  subtask_index,
  input  logic [63:0] ckpt_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [3:0]  status_code,
  output logic [2:0]  rescale_state,
  output logic [6:0]  current_out,
  output logic [6:0]  target_out,
  output logic [6:0]  min_out,
  output logic [6:0]  max_out,
  output logic [63:0] cutover_out,
  output logic [6:0]  drained_count,
  output logic [6:0]  ready_count
);
  import rht_pkg::*;

  dp_cmd_t cmd;

  rht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rht_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .mode            (mode),
    .op_slot         (op_slot),
    .parallelism     (parallelism),
    .par_min         (par_min),
    .par_max         (par_max),
    .subtask_index   (subtask_index),
    .ckpt_id         (ckpt_id),
    .ok              (ok),
    .status_code     (status_code),
    .rescale_state   (rescale_state),
    .current_out     (current_out),
    .target_out      (target_out),
    .min_out         (min_out),
    .max_out         (max_out),
    .cutover_out     (cutover_out),
    .drained_count   (drained_count),
    .ready_count     (ready_count)
  );

endmodule

### sim/tb_rescale_handshake_tracker_unit.sv
// ----------------------------------------------------------------------------
// tb_rescale_handshake_tracker_unit
// checks the rescale handshake tracker against a slot table predictor: a
// directed pass through every event and reject path, then random rescale
// flows with noise, random gaps on both channels and a scoreboard of results
// ----------------------------------------------------------------------------
module tb_rescale_handshake_tracker_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import rht_pkg::*;

  // mode with no meaning, expected to be rejected
  localparam logic [2:0] MODE_UNUSED = 3'd7;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  slot;
    logic [6:0]  par;
    logic [6:0]  pmin;
    logic [6:0]  pmax;
    logic [5:0]  sub;
    logic [63:0] ckpt;
  } event_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  code;
    logic [2:0]  state;
    logic [6:0]  cur;
    logic [6:0]  tgt;
    logic [6:0]  pmin;
    logic [6:0]  pmax;
    logic [63:0] ckpt;
    logic [6:0]  dcnt;
    logic [6:0]  rcnt;
  } result_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic [2:0] mode = 0;
  logic [3:0] op_slot = 0;
  logic [6:0] parallelism = 0, par_min = 0, par_max = 0;
  logic [5:0] subtask_index = 0;
  logic [63:0] ckpt_id = 0;
  logic ok;
  logic [3:0] status_code;
  logic [2:0] rescale_state;
  logic [6:0] current_out, target_out, min_out, max_out, drained_count, ready_count;
  logic [63:0] cutover_out;

  rescale_handshake_tracker_unit dut (.*);

  // predictor copy of the slot table
  logic        tv [NUM_SLOTS];
  logic [2:0]  tst [NUM_SLOTS];
  logic [6:0]  tcur [NUM_SLOTS], ttgt [NUM_SLOTS], tmin [NUM_SLOTS], tmax [NUM_SLOTS];
  logic [63:0] tck [NUM_SLOTS], tdm [NUM_SLOTS], trm [NUM_SLOTS];
  logic [6:0]  tdc [NUM_SLOTS], trc [NUM_SLOTS];

  event_t  pending_events[$];
  result_t expected_results[$];
  int      errors = 0;
  bit      gaps_on = 1;
  bit      hold_input = 0;

  logic   in_ready_seen = 0;
  event_t cur_ev;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_rescale_handshake_tracker_unit failed");
    $finish;
  end

  function automatic void clear_progress(int s);
    tck[s] = '0; tdm[s] = '0; trm[s] = '0; tdc[s] = '0; trc[s] = '0;
  endfunction

  // append one event to the pending queue
  function automatic void add_event(event_t e);
    pending_events.insert(pending_events.size(), e);
  endfunction

  // work out the result of one event and update the table
  function automatic result_t predict_event(event_t e);
    result_t r;
    int s;
    r = '0;
    s = int'(e.slot);
    if (e.mode != MODE_REGISTER && !tv[s]) begin
      r.code = SC_UNREG;
      return r;
    end
    r.code = SC_OK;
    case (e.mode)
      MODE_REGISTER: begin
        tv[s] = 1; tst[s] = ST_IDLE; tcur[s] = e.par; ttgt[s] = e.par;
        tmin[s] = e.pmin; tmax[s] = e.pmax; clear_progress(s); r.ok = 1;
      end
      MODE_REQUEST: begin
        if (tmin[s] == 0 && tmax[s] == 0) r.code = SC_NO_BOUNDS;
        else if (e.par < tmin[s]) r.code = SC_BELOW;
        else if (e.par > tmax[s]) r.code = SC_ABOVE;
        else if (e.par == tcur[s]) r.code = SC_EQUAL;
        else if (tst[s] == ST_PREP || tst[s] == ST_DRAIN || tst[s] == ST_CUT)
          r.code = SC_BUSY;
        else begin
          ttgt[s] = e.par; tst[s] = ST_PREP; clear_progress(s); r.ok = 1;
        end
      end
      MODE_CKPT: begin
        if (tst[s] != ST_PREP) r.code = SC_WRONG;
        else begin
          tck[s] = e.ckpt; tst[s] = ST_DRAIN; r.ok = 1;
        end
      end
      MODE_DRAINED: begin
        if (tst[s] != ST_DRAIN) r.code = SC_WRONG;
        else begin
          if (!tdm[s][e.sub]) begin
            tdm[s][e.sub] = 1; tdc[s] = 7'(tdc[s] + 7'd1);
          end
          if (tdc[s] >= tcur[s]) tst[s] = ST_CUT;
          r.ok = 1;
        end
      end
      MODE_READY: begin
        if (tst[s] != ST_CUT) r.code = SC_WRONG;
        else begin
          if (!trm[s][e.sub]) begin
            trm[s][e.sub] = 1; trc[s] = 7'(trc[s] + 7'd1);
          end
          if (trc[s] >= ttgt[s]) begin
            tcur[s] = ttgt[s]; tst[s] = ST_DONE;
          end
          r.ok = 1;
        end
      end
      MODE_ABORT: begin
        if (tst[s] == ST_IDLE || tst[s] == ST_DONE) r.code = SC_NO_ABORT;
        else begin
          tst[s] = ST_ABORT; ttgt[s] = tcur[s]; clear_progress(s); r.ok = 1;
        end
      end
      MODE_QUERY: r.ok = 1;
      default: r.code = SC_WRONG;
    endcase
    r.state = tst[s]; r.cur = tcur[s]; r.tgt = ttgt[s]; r.pmin = tmin[s];
    r.pmax = tmax[s]; r.ckpt = tck[s]; r.dcnt = tdc[s]; r.rcnt = trc[s];
    return r;
  endfunction

  function automatic event_t make_event(int m, int s, int p, int lo, int hi, int sb,
                                        logic [63:0] ck);
    event_t e;
    e.mode = 3'(m); e.slot = 4'(s); e.par = 7'(p); e.pmin = 7'(lo); e.pmax = 7'(hi);
    e.sub = 6'(sb); e.ckpt = ck;
    return e;
  endfunction

  function automatic event_t random_event(int m, int s);
    return make_event(m, s, $urandom_range(0, 127), $urandom_range(0, 127),
                      $urandom_range(0, 127), $urandom_range(0, 63),
                      {$urandom, $urandom});
  endfunction

  // driver: present events at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || in_ready_seen) begin
      if (pending_events.size() > 0 && !hold_input &&
          !(gaps_on && $urandom_range(0, 99) < 7)) begin
        cur_ev = pending_events.pop_front();
        expected_results.insert(expected_results.size(), predict_event(cur_ev));
        in_valid <= 1;
        mode <= cur_ev.mode; op_slot <= cur_ev.slot; parallelism <= cur_ev.par;
        par_min <= cur_ev.pmin; par_max <= cur_ev.pmax;
        subtask_index <= cur_ev.sub; ckpt_id <= cur_ev.ckpt;
      end else begin
        in_valid <= 0;
      end
    end
    out_ready <= !(gaps_on && $urandom_range(0, 99) < 7);
  end

  // note handshake at the rising edge for the driver
  always @(posedge clk) in_ready_seen <= in_valid && in_ready;

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    result_t act, exp_r;
    if (!rst && out_valid && out_ready) begin
      act = {ok, status_code, rescale_state, current_out, target_out, min_out,
             max_out, cutover_out, drained_count, ready_count};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, act);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (act.ok !== exp_r.ok || act.code !== exp_r.code || act.state !== exp_r.state ||
            act.cur !== exp_r.cur || act.tgt !== exp_r.tgt || act.pmin !== exp_r.pmin ||
            act.pmax !== exp_r.pmax || act.ckpt !== exp_r.ckpt ||
            act.dcnt !== exp_r.dcnt || act.rcnt !== exp_r.rcnt) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, act);
          errors++;
        end
      end
    end
  end

  // one rescale flow on a slot, with random content and at random an abort
  task automatic queue_flow(int s);
    int cur, tgt, n;
    cur = $urandom_range(1, 6);
    tgt = $urandom_range(1, 6);
    if (tgt == cur) tgt = cur + 1;
    add_event(make_event(MODE_REGISTER, s, cur, 1, $urandom_range(7, 64), 0, 0));
    add_event(make_event(MODE_REQUEST, s, tgt, 0, 0, 0, 0));
    add_event(make_event(MODE_CKPT, s, 0, 0, 0, 0, {$urandom, $urandom}));
    n = 0;
    while (n < cur + 2) begin
      add_event(make_event(MODE_DRAINED, s, 0, 0, 0, $urandom_range(0, 7), 0));
      n++;
    end
    n = 0;
    while (n < tgt + 3) begin
      add_event(make_event(MODE_READY, s, 0, 0, 0, $urandom_range(0, 7), 0));
      n++;
    end
    if ($urandom_range(0, 3) == 0)
      pending_events.insert($urandom_range(2, pending_events.size()),
                            make_event(MODE_ABORT, s, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_QUERY, s, 0, 0, 0, 0, 0));
  endtask

  initial begin
    int k;
    for (k = 0; k < NUM_SLOTS; k++) begin
      tv[k] = 0; tst[k] = '0; tcur[k] = '0; ttgt[k] = '0; tmin[k] = '0; tmax[k] = '0;
      clear_progress(k);
    end
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: unregistered, reject paths, extremes, unused mode
    add_event(make_event(MODE_QUERY, 15, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_REGISTER, 0, 4, 0, 0, 0, 0));
    add_event(make_event(MODE_REQUEST, 0, 5, 0, 0, 0, 0));
    add_event(make_event(MODE_REGISTER, 1, 4, 2, 64, 0, 0));
    add_event(make_event(MODE_REQUEST, 1, 1, 0, 0, 0, 0));
    add_event(make_event(MODE_REQUEST, 1, 127, 0, 0, 0, 0));
    add_event(make_event(MODE_REQUEST, 1, 4, 0, 0, 0, 0));
    add_event(make_event(MODE_ABORT, 1, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_DRAINED, 1, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_REQUEST, 1, 2, 0, 0, 0, 0));
    add_event(make_event(MODE_REQUEST, 1, 3, 0, 0, 0, 0));
    add_event(make_event(MODE_CKPT, 1, 0, 0, 0, 0, '1));
    add_event(make_event(MODE_DRAINED, 1, 0, 0, 0, 63, 0));
    add_event(make_event(MODE_DRAINED, 1, 0, 0, 0, 63, 0));
    add_event(make_event(MODE_ABORT, 1, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_ABORT, 1, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_UNUSED, 1, 0, 0, 0, 0, 0));
    add_event(make_event(MODE_REGISTER, 15, 127, 127, 127, 63, '1));
    add_event(make_event(MODE_QUERY, 15, 0, 0, 0, 0, 0));
    queue_flow(2);

    // pause the sender until the table has answered everything
    wait (pending_events.size() == 0);
    hold_input = 1;
    wait (expected_results.size() == 0);
    @(negedge clk);
    hold_input = 0;

    // random: mostly rescale flows, some noise on any slot
    k = 0;
    while (k < 1150) begin
      if (k > 400 && k < 600) gaps_on = 0;
      else gaps_on = 1;
      if ($urandom_range(0, 2) != 0) begin
        queue_flow($urandom_range(0, 15));
        k += 16;
      end else begin
        repeat (8) add_event(random_event($urandom_range(0, 7), $urandom_range(0, 15)));
        k += 8;
      end
      wait (pending_events.size() < 40);
    end
    wait (pending_events.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_rescale_handshake_tracker_unit passed");
    else $display("tb_rescale_handshake_tracker_unit failed");
    $finish;
  end
endmodule
